@@ rtl/core/mrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants for the Modbus RTU slave responder.
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam int unsigned MRS_RX_DEPTH = 32;

	localparam logic [7:0]  LOCAL_ADDR_RST = 8'd254;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  FC_READ        = 8'h03;
	localparam logic [7:0]  FC_WRITE       = 8'h06;
	localparam logic [7:0]  READ_BYTE_CNT  = 8'h02;
	localparam logic [15:0] HOLD_REG_ADDR  = 16'h0001;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] status_value;
	} mrs_in_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic        order_write;
		logic [15:0] order_value;
	} mrs_out_t;

endpackage

@@ rtl/core/modbus_rtu_slave_responder_unit.sv @@
// a byte that does not close a frame is taken and in_ready stays high for the next one
// closing byte: crc check of frame bytes 0-5, then crc of 5 (read) or 6 (write) reply bytes
// then, if the check passes, 7 or 8 reply bytes, one per cycle while the receiver takes them
// all crc work runs through one bit-serial crc step unit, one polynomial bit per cycle
// in_ready is low from the closing byte until the last reply byte is in the output register
// reset (arst_n low) clears phase, count, sequencer and output valid; address returns to 254
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder_unit
// Receives Modbus RTU bytes, checks read/write holding register frames and
// sends the reply frame one byte per transaction.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder_unit #(
	parameter int unsigned RX_DEPTH = mrs_pkg::MRS_RX_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  mrs_pkg::mrs_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output mrs_pkg::mrs_out_t out_data
);
	import mrs_pkg::*;

	localparam int unsigned CNT_W = $clog2(RX_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FCODE = 2'd1,
		PH_FRAME = 2'd2
	} rx_phase_t;

	typedef enum logic [3:0] {
		S_RECV  = 4'b0001,
		S_CHECK = 4'b0010,
		S_RCRC  = 4'b0100,
		S_SEND  = 4'b1000
	} seq_state_t;

	logic [7:0]       local_address_q;
	logic [1:0]       rx_phase_q;
	logic [CNT_W-1:0] rx_count_q;
	seq_state_t       state_q;
	logic [2:0]       bit_q;
	logic [2:0]       idx_q;
	logic             is_write_q;
	logic             out_valid_q;

	logic [7:0]       frame_q [8];
	logic [15:0]      crc_q;
	logic [7:0]       status_q;
	logic [15:0]      order_q;
	mrs_out_t         out_q;

	logic             in_fire;
	logic             room;
	logic [CNT_W-1:0] cnt_inc;
	logic             addr_match;
	logic             fcode_ok;
	logic             last_byte;
	logic [7:0]       step_byte;
	logic [15:0]      crc_opnd;
	logic [15:0]      crc_nxt;
	logic             frame_ok;
	logic [2:0]       body_last;
	logic             out_load;
	logic [7:0]       send_byte;

	function automatic logic [15:0] crc_bit(input logic [15:0] c);
		logic [15:0] sh;
		sh = c >> 1;
		return c[0] ? (sh ^ CRC_POLY) : sh;
	endfunction

	function automatic logic [7:0] msg_byte(input logic [2:0] idx, input logic wr,
			input logic [7:0] addr, input logic [7:0] status);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			3'd0: b = addr;
			3'd1: b = wr ? FC_WRITE : FC_READ;
			3'd2: b = wr ? 8'h00 : READ_BYTE_CNT;
			3'd3: b = wr ? 8'h01 : 8'h00;
			3'd4: b = wr ? 8'h00 : status;
			3'd5: b = status;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	assign in_ready   = (state_q == S_RECV);
	assign in_fire    = in_valid && in_ready;
	assign room       = (rx_count_q < CNT_W'(RX_DEPTH));
	assign cnt_inc    = rx_count_q + CNT_W'(1);
	assign addr_match = (in_data.rx_byte == local_address_q);
	assign fcode_ok   = (in_data.rx_byte == FC_READ) || (in_data.rx_byte == FC_WRITE);
	assign last_byte  = room && (rx_phase_q == PH_FRAME) && (cnt_inc == CNT_W'(8));

	// shared crc step unit: frame bytes during the check, reply bytes afterwards
	assign body_last = is_write_q ? 3'd5 : 3'd4;
	assign step_byte = (state_q == S_CHECK) ? frame_q[idx_q]
		: msg_byte(idx_q, is_write_q, local_address_q, status_q);
	assign crc_opnd  = (bit_q == 3'd0) ? (crc_q ^ {8'h00, step_byte}) : crc_q;
	assign crc_nxt   = crc_bit(crc_opnd);

	assign frame_ok = (crc_nxt == {frame_q[7], frame_q[6]})
		&& ({frame_q[2], frame_q[3]} == HOLD_REG_ADDR)
		&& ((frame_q[1] == FC_READ) || (frame_q[1] == FC_WRITE));

	assign out_load = (state_q == S_SEND) && (!out_valid_q || out_ready);

	always_comb begin
		if (idx_q <= body_last) begin
			send_byte = msg_byte(idx_q, is_write_q, local_address_q, status_q);
		end else if (idx_q == body_last + 3'd1) begin
			send_byte = crc_q[7:0];
		end else begin
			send_byte = crc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= LOCAL_ADDR_RST;
			rx_phase_q      <= PH_IDLE;
			rx_count_q      <= '0;
			state_q         <= S_RECV;
			bit_q           <= '0;
			idx_q           <= '0;
			is_write_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				local_address_q <= cfg_wr_data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_RECV: begin
					if (in_fire) begin
						if (!room) begin
							// buffer full: byte dropped, count restarts
							rx_count_q <= '0;
						end else begin
							case (rx_phase_q)
								PH_IDLE: begin
									if (addr_match) begin
										rx_count_q <= CNT_W'(1);
										rx_phase_q <= PH_FCODE;
									end else begin
										rx_count_q <= cnt_inc;
									end
								end
								PH_FCODE: begin
									if (fcode_ok) begin
										rx_count_q <= cnt_inc;
										rx_phase_q <= PH_FRAME;
									end else begin
										rx_count_q <= '0;
										rx_phase_q <= PH_IDLE;
									end
								end
								PH_FRAME: begin
									if (last_byte) begin
										rx_count_q <= '0;
										rx_phase_q <= PH_IDLE;
										state_q    <= S_CHECK;
										bit_q      <= '0;
										idx_q      <= '0;
									end else begin
										rx_count_q <= cnt_inc;
									end
								end
								default: begin
									rx_count_q <= '0;
									rx_phase_q <= PH_IDLE;
								end
							endcase
						end
					end
				end
				S_CHECK: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (idx_q == 3'd5) begin
							idx_q <= '0;
							if (frame_ok) begin
								is_write_q <= (frame_q[1] == FC_WRITE);
								state_q    <= S_RCRC;
							end else begin
								state_q <= S_RECV;
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_RCRC: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (idx_q == body_last) begin
							idx_q   <= '0;
							state_q <= S_SEND;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_SEND: begin
					if (out_load) begin
						if (idx_q == body_last + 3'd2) begin
							idx_q   <= '0;
							state_q <= S_RECV;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_RECV;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && room) begin
			// an address match restarts the frame at slot 0
			if ((rx_phase_q == PH_IDLE) && addr_match) begin
				frame_q[0] <= in_data.rx_byte;
			end else if (rx_count_q < CNT_W'(8)) begin
				frame_q[rx_count_q[2:0]] <= in_data.rx_byte;
			end
		end
		if (in_fire && last_byte) begin
			status_q <= in_data.status_value;
			crc_q    <= CRC_INIT;
		end
		if (state_q == S_CHECK) begin
			if ((bit_q == 3'd7) && (idx_q == 3'd5)) begin
				crc_q   <= CRC_INIT;
				order_q <= {frame_q[4], frame_q[5]};
			end else begin
				crc_q <= crc_nxt;
			end
		end
		if (state_q == S_RCRC) begin
			crc_q <= crc_nxt;
		end
		if (out_load) begin
			out_q.tx_byte     <= send_byte;
			out_q.tx_last     <= (idx_q == body_last + 3'd2);
			out_q.order_write <= is_write_q && (idx_q == 3'd0);
			out_q.order_value <= (is_write_q && (idx_q == 3'd0)) ? order_q : 16'h0000;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/mrs_checker.sv @@
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks on the responder's reply stream and input stall.
// ----------------------------------------------------------------------------
module mrs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input mrs_pkg::mrs_out_t out_data
);
	import mrs_pkg::*;

	// a stalled reply transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("reply byte changed while stalled");

	// reply bytes follow each other without gaps until the last one
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.tx_last |=> out_valid)
		else $error("gap inside reply frame");

	// no receive while a reply frame is still being produced
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_last |-> !in_ready)
		else $error("input taken in the middle of a reply");

	// order word only rides with the write flag
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.order_write |-> out_data.order_value == 16'h0000)
		else $error("order word without write flag");

	// write flag sits on the first byte, never on the last
	a_wr_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.order_write |-> !out_data.tx_last)
		else $error("write flag on closing byte");

endmodule

bind modbus_rtu_slave_responder_unit mrs_checker u_mrs_checker (.*);
